// ===== hw/rtl/ukt_pkg.sv =====
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types and codes of the unsorted key table: operation and status
// codes, the stored entry and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package ukt_pkg;

  localparam int KEY_W = 32;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    scan_en;
    logic    rd_last;
    logic    ins_wr;
    logic    move_wr;
    logic    res_ld;
    logic    res_take;
    status_t res_status;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic hit;
    logic miss;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/ukt_ifs.sv =====
// ----------------------------------------------------------------------------
// ukt_req_if / ukt_rsp_if
// Valid/ready channels of the unsorted key table: request and response.
// ----------------------------------------------------------------------------
interface ukt_req_if;
  logic                             valid;
  logic                             ready;
  ukt_pkg::op_t                     operation;
  logic signed [ukt_pkg::KEY_W-1:0] item_key;
  logic signed [ukt_pkg::KEY_W-1:0] item_id;

  modport source (output valid, operation, item_key, item_id, input ready);
  modport sink   (input valid, operation, item_key, item_id, output ready);
endinterface

interface ukt_rsp_if #(
  parameter int CNT_W = 7
);
  logic                             valid;
  logic                             ready;
  ukt_pkg::status_t                 status;
  logic signed [ukt_pkg::KEY_W-1:0] found_key;
  logic signed [ukt_pkg::KEY_W-1:0] found_id;
  logic [CNT_W-1:0]                 count_after;

  modport source (output valid, status, found_key, found_id, count_after, input ready);
  modport sink   (input valid, status, found_key, found_id, count_after, output ready);
endinterface

// ===== hw/rtl/ukt_datapath.sv =====
// ----------------------------------------------------------------------------
// ukt_datapath
// Entry memory, count, scan pipeline, result and output registers.
// ----------------------------------------------------------------------------
module ukt_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ukt_pkg::cmd_t                    cmd,
  output ukt_pkg::sts_t                    sts,
  input  ukt_pkg::op_t                     operation,
  input  logic signed [ukt_pkg::KEY_W-1:0] item_key,
  input  logic signed [ukt_pkg::KEY_W-1:0] item_id,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output ukt_pkg::status_t                 rsp_status,
  output logic signed [ukt_pkg::KEY_W-1:0] rsp_key,
  output logic signed [ukt_pkg::KEY_W-1:0] rsp_id,
  output logic [$clog2(CAPACITY+1)-1:0]    rsp_count
);
  import ukt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  entry_t mem [CAPACITY];
  entry_t rd_data;
  entry_t wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  op_t                 op;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] id;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_last;
  logic [CW-1:0]       idx;
  logic                chk;
  logic [AW-1:0]       chk_idx;
  logic [AW-1:0]       pos;
  logic                issue;

  status_t             res_status;
  logic signed [KEY_W-1:0] res_key;
  logic signed [KEY_W-1:0] res_id;

  assign count_last = count - 1'b1;
  assign issue      = cmd.scan_en && (idx < count);
  assign rd_addr    = cmd.rd_last ? count_last[AW-1:0] : idx[AW-1:0];
  assign wr_en      = cmd.ins_wr | cmd.move_wr;
  assign wr_addr    = cmd.ins_wr ? count[AW-1:0] : pos;
  assign wr_data    = cmd.ins_wr ? entry_t'{key: key, id: id} : rd_data;

  assign sts.op       = op;
  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.hit      = chk && (rd_data.key == key);
  assign sts.miss     = !chk && (idx >= count);
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      chk       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      chk <= issue;
      if (cmd.ins_wr) begin
        count <= count + 1'b1;
      end else if (cmd.move_wr) begin
        count <= count_last;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      key <= item_key;
      id  <= item_id;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (issue) begin
      chk_idx <= idx[AW-1:0];
    end
    // first match only: later reads still in the pipe must not move pos
    if (cmd.scan_en && sts.hit) begin
      pos <= chk_idx;
    end
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      res_key    <= cmd.res_take ? rd_data.key : '0;
      res_id     <= cmd.res_take ? rd_data.id : '0;
    end
    if (cmd.emit) begin
      rsp_status <= res_status;
      rsp_key    <= res_key;
      rsp_id     <= res_id;
      rsp_count  <= count;
    end
  end

endmodule

// ===== hw/rtl/ukt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ukt_ctrl
// Sequencer: decode, key scan, last-entry move on delete, result hand-off.
// ----------------------------------------------------------------------------
module ukt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output ukt_pkg::cmd_t cmd,
  input  ukt_pkg::sts_t sts
);
  import ukt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_RESULT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op) inside
          OP_INSERT: begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = sts.full ? ST_FULL : ST_OK;
            cmd.ins_wr     = !sts.full;
            state_next     = S_RESULT;
          end
          OP_DELETE, OP_SEARCH: begin
            state_next = S_SCAN;
          end
          default: begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.hit) begin
          if (sts.op == OP_DELETE) begin
            state_next = S_MOVE_RD;
          end else begin
            cmd.res_ld     = 1'b1;
            cmd.res_take   = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_RESULT;
          end
        end else if (sts.miss) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_MISS;
          state_next     = S_RESULT;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr    = 1'b1;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/unsorted_key_table_unit.sv =====
// ----------------------------------------------------------------------------
// unsorted_key_table_unit
// Unsorted (key, id) table with append insert, swap-remove delete and
// linear search.
// ----------------------------------------------------------------------------
// Usage:
//   req carries operation (insert, delete, search), item_key and item_id;
//   rsp returns status, found_key, found_id and count_after, one response
//   per request, in order. Both are valid/ready; a transfer happens when
//   valid and ready are both high.
//   One request is worked on at a time; req.ready is high only while idle.
//   Each request is decoded first. Insert appends at position count unless
//   the table is full; search and delete scan the entries from position
//   zero and stop at the first matching key or at count (a miss); a delete
//   hit then reads the last entry and writes it over the matched one.
//   The scan reads one entry per cycle through the single read port of the
//   entry memory.
//   The response sits in an output register: the next request is taken
//   while it waits, and a stalled rsp only holds back the following result.
//   Reset empties the table (count zero) and drops any pending response.
// ----------------------------------------------------------------------------
module unsorted_key_table_unit #(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst,
  ukt_req_if.sink   req,
  ukt_rsp_if.source rsp
);
  import ukt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [CW-1:0]    rsp_count;

  ukt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ukt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (req.operation),
    .item_key   (req.item_key),
    .item_id    (req.item_id),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_key    (rsp.found_key),
    .rsp_id     (rsp.found_id),
    .rsp_count  (rsp_count)
  );

  assign rsp.count_after = rsp_count;

endmodule

// ===== hw/rtl/ukt_checker.sv =====
// ----------------------------------------------------------------------------
// ukt_checker
// Port-level checks of the unsorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module ukt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input ukt_pkg::status_t                 rsp_status,
  input logic signed [ukt_pkg::KEY_W-1:0] found_key,
  input logic signed [ukt_pkg::KEY_W-1:0] found_id,
  input logic [$clog2(CAPACITY+1)-1:0]    count_after
);
  import ukt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> (count_after == CW'(CAPACITY)))
    else $error("full reported below capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (found_key == '0) && (found_id == '0)
      && (count_after <= CW'(CAPACITY)))
    else $error("failed operation returned data");

endmodule

bind unsorted_key_table_unit ukt_checker #(
  .CAPACITY (CAPACITY)
) u_ukt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .found_key   (rsp.found_key),
  .found_id    (rsp.found_id),
  .count_after (rsp.count_after)
);
